// File: design/rdpt_pkg.sv
// shared types and constants for the radius detect point table
package rdpt_pkg;

    localparam int COORD_W  = 24;
    localparam int DIFF_W   = 25;
    localparam int SQ_W     = 48;
    localparam int DSQ_W    = 49;
    localparam int RADIUS_W = 23;
    localparam int RSQ_W    = 46;
    localparam int INDEX_W  = 5;
    localparam int COUNT_W  = 6;
    localparam int RKIND_W  = 2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [RKIND_W-1:0] RK_POINT    = 2'd0;
    localparam logic [RKIND_W-1:0] RK_SUMMARY  = 2'd1;
    localparam logic [RKIND_W-1:0] RK_LOAD_ACK = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
    } cmd_item_t;

    typedef struct packed {
        logic [RKIND_W-1:0]        result_kind;
        logic [INDEX_W-1:0]        point_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      newly_detected;
        logic [COUNT_W-1:0]        in_range_count;
        logic [COUNT_W-1:0]        detected_total;
        logic [INDEX_W-1:0]        nearest_index;
        logic [DSQ_W-1:0]          nearest_dist_sq;
        logic                      nearest_valid;
        logic                      load_status;
        logic                      last;
    } rsp_item_t;

endpackage

// File: design/rdpt_stream_if.sv
// valid/ready stream channel carrying one item type
interface rdpt_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// File: design/rdpt_ram.sv
// generic simple dual port ram with registered read
module rdpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: design/radius_detect_point_table.sv
// radius detect point table: stored point list with fixed radius query scan
// Load items append a point to a table held in one ram, are refused with load_status set
// when the table is full, and are acknowledged by one item in the cycle after acceptance.
// A query streams the n stored points out of the ram one per cycle while the output is not
// stalled, through a four stage difference, square, sum and compare pipeline, and emits an
// item for each point within the radius, then a summary item; with no output stall the next
// item can be taken in the same cycle as the summary appears, the single ram read port setting one point per cycle.
// A new item is taken only once the previous one has finished. The radius register should be
// written only while the block is idle.
module radius_detect_point_table #(
    parameter int MAX_POINTS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rdpt_stream_if.sink                    cmd,
    rdpt_stream_if.source                  rsp,
    input  logic                           cfg_we,
    input  logic [rdpt_pkg::RADIUS_W-1:0]  cfg_wdata
);
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CW    = rdpt_pkg::COORD_W;
    localparam int PT_W  = 2 * CW;

    rdpt_pkg::state_t state_reg, state_next;

    logic [rdpt_pkg::RADIUS_W-1:0] radius_reg;
    logic [rdpt_pkg::RSQ_W-1:0]    rsq_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              det_cnt_reg;
    logic [MAX_POINTS-1:0]         det_mask_reg;
    logic [CNT_W-1:0]              issue_reg;
    logic [CNT_W-1:0]              inr_cnt_reg;
    logic signed [CW-1:0]          qx_reg;
    logic signed [CW-1:0]          qy_reg;

    logic                                s0_vld_reg;
    logic [IDX_W-1:0]                    s0_idx_reg;
    logic                                s1_vld_reg;
    logic [IDX_W-1:0]                    s1_idx_reg;
    logic [PT_W-1:0]                     s1_pt_reg;
    logic signed [rdpt_pkg::DIFF_W-1:0]  s1_dx_reg;
    logic signed [rdpt_pkg::DIFF_W-1:0]  s1_dy_reg;
    logic                                s2_vld_reg;
    logic [IDX_W-1:0]                    s2_idx_reg;
    logic [PT_W-1:0]                     s2_pt_reg;
    logic [rdpt_pkg::SQ_W-1:0]           s2_sqx_reg;
    logic [rdpt_pkg::SQ_W-1:0]           s2_sqy_reg;
    logic                                s3_vld_reg;
    logic [IDX_W-1:0]                    s3_idx_reg;
    logic [PT_W-1:0]                     s3_pt_reg;
    logic [rdpt_pkg::DSQ_W-1:0]          s3_dsq_reg;

    logic                                best_vld_reg;
    logic [IDX_W-1:0]                    best_idx_reg;
    logic [rdpt_pkg::DSQ_W-1:0]          best_dsq_reg;

    logic                  out_vld_reg, out_vld_next;
    rdpt_pkg::rsp_item_t   out_reg, out_next;

    logic                  stall;
    logic                  out_free;
    logic                  accept;
    logic                  is_load;
    logic                  is_query;
    logic                  full;
    logic                  issue_more;
    logic                  pipe_empty;
    logic                  rd_en;
    logic                  summ_emit;
    logic                  advance;
    logic                  s3_hit;
    logic                  s3_better;
    logic                  s3_fresh;
    logic                  ram_we;
    logic [PT_W-1:0]       ram_rdata;
    logic [CW-1:0]         ram_x;
    logic [CW-1:0]         ram_y;

    logic signed [2*rdpt_pkg::DIFF_W-1:0] sqx_full;
    logic signed [2*rdpt_pkg::DIFF_W-1:0] sqy_full;

    logic [IDX_W+4:0]      s3_idx_ext;
    logic [IDX_W+4:0]      best_idx_ext;
    logic [CNT_W+5:0]      inr_cnt_ext;
    logic [CNT_W+5:0]      det_cnt_ext;

    // point table: x in the upper half, y in the lower half
    rdpt_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata ({cmd.payload.coord_x, cmd.payload.coord_y}),
        .re    (rd_en),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_x = ram_rdata[PT_W-1:CW];
    assign ram_y = ram_rdata[CW-1:0];

    assign stall      = out_vld_reg && !rsp.ready;
    assign out_free   = !stall;
    assign accept     = cmd.valid && cmd.ready;
    assign is_load    = cmd.payload.kind == rdpt_pkg::KIND_LOAD;
    assign is_query   = cmd.payload.kind == rdpt_pkg::KIND_QUERY;
    assign full       = cnt_reg == CNT_W'(MAX_POINTS);
    assign ram_we     = accept && is_load && !full;
    assign issue_more = issue_reg < cnt_reg;
    assign pipe_empty = !s0_vld_reg && !s1_vld_reg && !s2_vld_reg && !s3_vld_reg;
    assign advance    = (state_reg == rdpt_pkg::ST_SCAN) && !stall;

    assign sqx_full = s1_dx_reg * s1_dx_reg;
    assign sqy_full = s1_dy_reg * s1_dy_reg;

    assign s3_hit    = s3_vld_reg && (s3_dsq_reg <= {3'b000, rsq_reg});
    assign s3_better = !best_vld_reg || (s3_dsq_reg < best_dsq_reg);
    assign s3_fresh  = !det_mask_reg[s3_idx_reg];

    assign s3_idx_ext   = (IDX_W + 5)'(s3_idx_reg);
    assign best_idx_ext = (IDX_W + 5)'(best_idx_reg);
    assign inr_cnt_ext  = (CNT_W + 6)'(inr_cnt_reg);
    assign det_cnt_ext  = (CNT_W + 6)'(det_cnt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rdpt_pkg::ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    state_next = (cnt_reg == '0) ? rdpt_pkg::ST_SUMMARY : rdpt_pkg::ST_SCAN;
                end
            end
            rdpt_pkg::ST_SCAN:
            begin
                if (!stall && !issue_more && pipe_empty)
                begin
                    state_next = rdpt_pkg::ST_SUMMARY;
                end
            end
            rdpt_pkg::ST_SUMMARY:
            begin
                if (out_free)
                begin
                    state_next = rdpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rdpt_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        cmd.ready = 1'b0;
        rd_en     = 1'b0;
        summ_emit = 1'b0;
        case (state_reg)
            rdpt_pkg::ST_IDLE:
            begin
                cmd.ready = out_free;
            end
            rdpt_pkg::ST_SCAN:
            begin
                rd_en = !stall && issue_more;
            end
            rdpt_pkg::ST_SUMMARY:
            begin
                summ_emit = out_free;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    // output item selection
    always_comb
    begin
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !rsp.ready;
        if (accept && is_load)
        begin
            out_next             = '0;
            out_next.result_kind = rdpt_pkg::RK_LOAD_ACK;
            out_next.load_status = full;
            out_next.last        = 1'b1;
            out_vld_next         = 1'b1;
        end
        else if (advance && s3_hit)
        begin
            out_next                = '0;
            out_next.result_kind    = rdpt_pkg::RK_POINT;
            out_next.point_index    = s3_idx_ext[4:0];
            out_next.point_x        = s3_pt_reg[PT_W-1:CW];
            out_next.point_y        = s3_pt_reg[CW-1:0];
            out_next.newly_detected = s3_fresh;
            out_vld_next            = 1'b1;
        end
        else if (summ_emit)
        begin
            out_next                = '0;
            out_next.result_kind    = rdpt_pkg::RK_SUMMARY;
            out_next.in_range_count = inr_cnt_ext[5:0];
            out_next.detected_total = det_cnt_ext[5:0];
            if (best_vld_reg)
            begin
                out_next.nearest_index   = best_idx_ext[4:0];
                out_next.nearest_dist_sq = best_dsq_reg;
                out_next.nearest_valid   = 1'b1;
            end
            out_next.last = 1'b1;
            out_vld_next  = 1'b1;
        end
    end

    assign rsp.valid   = out_vld_reg;
    assign rsp.payload = out_reg;

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept && is_query)
        begin
            qx_reg <= cmd.payload.coord_x;
            qy_reg <= cmd.payload.coord_y;
        end
        if (advance)
        begin
            s0_idx_reg <= issue_reg[IDX_W-1:0];
            s1_idx_reg <= s0_idx_reg;
            s1_pt_reg  <= ram_rdata;
            s1_dx_reg  <= $signed({qx_reg[CW-1], qx_reg}) - $signed({ram_x[CW-1], ram_x});
            s1_dy_reg  <= $signed({qy_reg[CW-1], qy_reg}) - $signed({ram_y[CW-1], ram_y});
            s2_idx_reg <= s1_idx_reg;
            s2_pt_reg  <= s1_pt_reg;
            s2_sqx_reg <= sqx_full[rdpt_pkg::SQ_W-1:0];
            s2_sqy_reg <= sqy_full[rdpt_pkg::SQ_W-1:0];
            s3_idx_reg <= s2_idx_reg;
            s3_pt_reg  <= s2_pt_reg;
            s3_dsq_reg <= {1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg};
            if (s3_vld_reg && s3_better)
            begin
                best_idx_reg <= s3_idx_reg;
                best_dsq_reg <= s3_dsq_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rdpt_pkg::ST_IDLE;
            radius_reg   <= '0;
            rsq_reg      <= '0;
            cnt_reg      <= '0;
            det_cnt_reg  <= '0;
            det_mask_reg <= '0;
            issue_reg    <= '0;
            inr_cnt_reg  <= '0;
            best_vld_reg <= 1'b0;
            s0_vld_reg   <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            rsq_reg     <= radius_reg * radius_reg;
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            if (ram_we)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (accept && is_query)
            begin
                issue_reg    <= '0;
                inr_cnt_reg  <= '0;
                best_vld_reg <= 1'b0;
            end
            else if (advance)
            begin
                if (rd_en)
                begin
                    issue_reg <= issue_reg + 1'b1;
                end
                s0_vld_reg <= rd_en;
                s1_vld_reg <= s0_vld_reg;
                s2_vld_reg <= s1_vld_reg;
                s3_vld_reg <= s2_vld_reg;
                if (s3_vld_reg)
                begin
                    best_vld_reg <= 1'b1;
                end
                if (s3_hit)
                begin
                    inr_cnt_reg <= inr_cnt_reg + 1'b1;
                    if (s3_fresh)
                    begin
                        det_mask_reg[s3_idx_reg] <= 1'b1;
                        det_cnt_reg              <= det_cnt_reg + 1'b1;
                    end
                end
            end
        end
    end

    // detected total tracks the detected set
    a_det_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(det_mask_reg) == det_cnt_reg)
        else $error("detected count out of step with detected set");

    // scan never reads past the stored points
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg <= cnt_reg)
        else $error("scan read past table fill");

    // no new item while a query is under way
    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != rdpt_pkg::ST_IDLE |-> !cmd.ready)
        else $error("item accepted during query");

    // a stalled output freezes the scan pipeline
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rdpt_pkg::ST_SCAN && stall) |=> $stable(s3_vld_reg) && $stable(issue_reg))
        else $error("scan pipeline moved under stall");

    // the scan pipeline drains before the summary
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rdpt_pkg::ST_SUMMARY |-> pipe_empty)
        else $error("summary issued with points in flight");
endmodule

// File: test/radius_detect_point_table_tb.sv
`timescale 1ns / 100ps
// testbench for radius_detect_point_table: directed and random items checked by a scoreboard
module radius_detect_point_table_tb;

    localparam int TABLE_DEPTH  = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int COORD_MAX    = 8388607;
    localparam int COORD_MIN    = -8388608;
    localparam int RADIUS_MAX   = 8388607;
    localparam int RANDOM_ITEMS = 95;
    localparam int PHASES       = 5;
    localparam int DRAIN_CYCLES = 48;

    class point_table_scoreboard;
        logic signed [rdpt_pkg::COORD_W-1:0] stored_x [TABLE_DEPTH];
        logic signed [rdpt_pkg::COORD_W-1:0] stored_y [TABLE_DEPTH];
        int unsigned                         stored_count;
        bit                                  seen_flag [TABLE_DEPTH];
        logic [rdpt_pkg::COUNT_W-1:0]        seen_total;
        logic [rdpt_pkg::RADIUS_W-1:0]       radius;
        rdpt_pkg::rsp_item_t                 awaited_rsp [$];
        int unsigned                         mismatches;
        int unsigned                         n_loads, n_refused, n_queries, n_empty_queries;
        int unsigned                         n_checked, n_points, n_fresh;

        function new();
            stored_count = 0;
            seen_total   = '0;
            radius       = '0;
            mismatches   = 0;
            foreach (seen_flag[i])
                seen_flag[i] = 1'b0;
        endfunction

        function void set_radius(logic [rdpt_pkg::RADIUS_W-1:0] r);
            radius = r;
        endfunction

        function int awaited_count();
            return awaited_rsp.size();
        endfunction

        function void add_awaited(rdpt_pkg::rsp_item_t r);
            awaited_rsp = {awaited_rsp, r};
        endfunction

        // work out every result a command will produce
        function void note_cmd(rdpt_pkg::cmd_item_t it);
            rdpt_pkg::rsp_item_t          r;
            longint                       dx, dy;
            logic [rdpt_pkg::DSQ_W-1:0]   dsq, best_dsq;
            logic [rdpt_pkg::RSQ_W-1:0]   rsq;
            logic [rdpt_pkg::COUNT_W-1:0] hits;
            int unsigned                  best_idx;
            bit                           have_best;

            if (it.kind == rdpt_pkg::KIND_LOAD)
            begin
                n_loads++;
                r = '0;
                r.result_kind = rdpt_pkg::RK_LOAD_ACK;
                r.last = 1'b1;
                if (stored_count < TABLE_DEPTH)
                begin
                    stored_x[stored_count] = it.coord_x;
                    stored_y[stored_count] = it.coord_y;
                    stored_count++;
                end
                else
                begin
                    r.load_status = 1'b1;
                    n_refused++;
                end
                add_awaited(r);
                return;
            end

            n_queries++;
            if (stored_count == 0)
                n_empty_queries++;
            rsq = rdpt_pkg::RSQ_W'(radius) * rdpt_pkg::RSQ_W'(radius);
            hits = '0;
            best_idx = 0;
            best_dsq = '0;
            have_best = 1'b0;
            for (int i = 0; i < stored_count; i++)
            begin
                dx = longint'($signed(it.coord_x)) - longint'(stored_x[i]);
                dy = longint'($signed(it.coord_y)) - longint'(stored_y[i]);
                dsq = rdpt_pkg::DSQ_W'(dx * dx + dy * dy);
                if (!have_best || dsq < best_dsq)
                begin
                    have_best = 1'b1;
                    best_dsq = dsq;
                    best_idx = i;
                end
                if (dsq <= rsq)
                begin
                    r = '0;
                    r.result_kind = rdpt_pkg::RK_POINT;
                    r.point_index = rdpt_pkg::INDEX_W'(i);
                    r.point_x = stored_x[i];
                    r.point_y = stored_y[i];
                    r.newly_detected = !seen_flag[i];
                    if (!seen_flag[i])
                    begin
                        seen_flag[i] = 1'b1;
                        seen_total = seen_total + 1'b1;
                    end
                    hits = hits + 1'b1;
                    add_awaited(r);
                end
            end
            r = '0;
            r.result_kind = rdpt_pkg::RK_SUMMARY;
            r.in_range_count = hits;
            r.detected_total = seen_total;
            if (have_best)
            begin
                r.nearest_index = rdpt_pkg::INDEX_W'(best_idx);
                r.nearest_dist_sq = best_dsq;
                r.nearest_valid = 1'b1;
            end
            r.last = 1'b1;
            add_awaited(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_rsp(rdpt_pkg::rsp_item_t got);
            rdpt_pkg::rsp_item_t want;

            n_checked++;
            if (got.result_kind == rdpt_pkg::RK_POINT)
            begin
                n_points++;
                if (got.newly_detected)
                    n_fresh++;
            end
            if (awaited_rsp.size() == 0)
            begin
                $error("result_kind %0d arrived with no result outstanding", got.result_kind);
                mismatches++;
                return;
            end
            want = awaited_rsp.pop_front();
            compare_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
            compare_field("point_index", 64'(want.point_index), 64'(got.point_index));
            compare_field("point_x", 64'($unsigned(want.point_x)), 64'($unsigned(got.point_x)));
            compare_field("point_y", 64'($unsigned(want.point_y)), 64'($unsigned(got.point_y)));
            compare_field("newly_detected", 64'(want.newly_detected),
                          64'(got.newly_detected));
            compare_field("in_range_count", 64'(want.in_range_count),
                          64'(got.in_range_count));
            compare_field("detected_total", 64'(want.detected_total),
                          64'(got.detected_total));
            compare_field("nearest_index", 64'(want.nearest_index), 64'(got.nearest_index));
            compare_field("nearest_dist_sq", 64'(want.nearest_dist_sq),
                          64'(got.nearest_dist_sq));
            compare_field("nearest_valid", 64'(want.nearest_valid), 64'(got.nearest_valid));
            compare_field("load_status", 64'(want.load_status), 64'(got.load_status));
            compare_field("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [rdpt_pkg::RADIUS_W-1:0] cfg_wdata;

    rdpt_stream_if #(.item_t(rdpt_pkg::cmd_item_t)) cmd_if ();
    rdpt_stream_if #(.item_t(rdpt_pkg::rsp_item_t)) rsp_if ();

    point_table_scoreboard sb = new();

    int          idle_pct = 7;
    int          hold_request = 0;
    int          cycle_count = 0;
    int          cur_radius = 0;
    int          radius_writes = 0;
    int          cluster_x, cluster_y;

    radius_detect_point_table #(
        .MAX_POINTS (TABLE_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // result side: random stalls plus a long hold-off on request
    initial
    begin
        int hold_left;

        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_rsp(rsp_if.payload);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    function automatic int any_coord();
        logic signed [rdpt_pkg::COORD_W-1:0] v;
        v = rdpt_pkg::COORD_W'($urandom);
        return int'(v);
    endfunction

    function automatic int clamp_coord(int v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_cmd(logic kind, int x, int y);
        rdpt_pkg::cmd_item_t it;

        it.kind = kind;
        it.coord_x = x[rdpt_pkg::COORD_W-1:0];
        it.coord_y = y[rdpt_pkg::COORD_W-1:0];
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.payload <= it;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        sb.note_cmd(it);
    endtask

    task automatic end_burst();
        cmd_if.valid <= 1'b0;
        while (sb.awaited_count() != 0)
            @(posedge clk);
    endtask

    task automatic write_radius(int r);
        cfg_we <= 1'b1;
        cfg_wdata <= r[rdpt_pkg::RADIUS_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_radius(r[rdpt_pkg::RADIUS_W-1:0]);
        cur_radius = r;
        radius_writes++;
    endtask

    task automatic send_random_cmd();
        int k, span;

        if ($urandom_range(99) < 35)
        begin
            if ($urandom_range(99) < 75)
                send_cmd(rdpt_pkg::KIND_LOAD, clamp_coord(cluster_x + jitter(1024)),
                         clamp_coord(cluster_y + jitter(1024)));
            else
                send_cmd(rdpt_pkg::KIND_LOAD, any_coord(), any_coord());
        end
        else if (sb.stored_count > 0 && $urandom_range(99) < 70)
        begin
            // aim close to a stored point so the radius test goes both ways
            k = $urandom_range(0, sb.stored_count - 1);
            span = ((cur_radius < 4096) ? cur_radius : 4096) + 4;
            send_cmd(rdpt_pkg::KIND_QUERY, clamp_coord(int'(sb.stored_x[k]) + jitter(span)),
                     clamp_coord(int'(sb.stored_y[k]) + jitter(span)));
        end
        else
            send_cmd(rdpt_pkg::KIND_QUERY, any_coord(), any_coord());
    endtask

    initial
    begin
        int r;

        rst_n <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.payload <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        cluster_x = int'($urandom_range(0, 400000)) - 200000;
        cluster_y = int'($urandom_range(0, 400000)) - 200000;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // radius still at its reset value of zero
        send_cmd(rdpt_pkg::KIND_QUERY, 0, 0);
        send_cmd(rdpt_pkg::KIND_LOAD, 0, 0);
        send_cmd(rdpt_pkg::KIND_LOAD, COORD_MAX, COORD_MAX);
        send_cmd(rdpt_pkg::KIND_LOAD, COORD_MIN, COORD_MIN);
        send_cmd(rdpt_pkg::KIND_LOAD, COORD_MAX, COORD_MIN);
        send_cmd(rdpt_pkg::KIND_LOAD, 16, -16);
        send_cmd(rdpt_pkg::KIND_LOAD, -16, 16);
        send_cmd(rdpt_pkg::KIND_QUERY, 0, 0);
        send_cmd(rdpt_pkg::KIND_QUERY, 0, 0);
        send_cmd(rdpt_pkg::KIND_QUERY, COORD_MIN, COORD_MIN);
        send_cmd(rdpt_pkg::KIND_QUERY, 8, -8);
        send_cmd(rdpt_pkg::KIND_QUERY, COORD_MAX, COORD_MAX);
        end_burst();

        write_radius(RADIUS_MAX);
        send_cmd(rdpt_pkg::KIND_QUERY, 0, 0);
        send_cmd(rdpt_pkg::KIND_QUERY, COORD_MAX, 0);
        send_cmd(rdpt_pkg::KIND_QUERY, COORD_MIN, COORD_MAX);
        end_burst();

        write_radius(32);
        send_cmd(rdpt_pkg::KIND_QUERY, 16, 16);
        send_cmd(rdpt_pkg::KIND_QUERY, -24, 40);
        end_burst();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0: r = $urandom_range(16, 255);
                1: r = $urandom_range(512, 4095);
                2: r = $urandom & RADIUS_MAX;
                default: r = $urandom_range(4096, 65535);
            endcase
            write_radius(r);
            idle_pct = (ph == 1) ? 0 : 7;
            if (ph == 3)
                hold_request = 400;
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
                send_random_cmd();
            end_burst();
        end

        idle_pct = 7;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("items %0d: loads %0d (refused when full %0d), queries %0d (on empty table %0d)",
                 sb.n_loads + sb.n_queries, sb.n_loads, sb.n_refused, sb.n_queries,
                 sb.n_empty_queries);
        $display("results %0d: in-range points %0d (new %0d), radius settings %0d",
                 sb.n_checked, sb.n_points, sb.n_fresh, radius_writes);
        if (sb.mismatches == 0 && sb.awaited_count() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
design/rdpt_pkg.sv
design/rdpt_stream_if.sv
design/rdpt_ram.sv
design/radius_detect_point_table.sv
test/radius_detect_point_table_tb.sv
